// ===== rtl/core/ngvpa_pkg.sv =====
package ngvpa_pkg;

    localparam int MAX_PSDU_BYTES = 65535;

    // bytes beyond the 16-bit field can never arrive
    localparam int BYTES_CAP  = (MAX_PSDU_BYTES > 65535) ? 65535 : MAX_PSDU_BYTES;

    localparam int SYMBOL_NS     = 8000;
    localparam int LTF_1X_NS     = 4800;
    localparam int LTF_2X_NS     = 8000;
    localparam int LTF_2X_REP_NS = 14400;
    localparam int SERVICE_BITS  = 16;
    localparam int TAIL_BITS     = 6;

    localparam int SYM_MAX = 65535;
    localparam int MID_MAX = 16383;
    localparam int PAY_MAX = 1073741823;

    localparam int DBPS_W   = 11;
    localparam int DBPS_MAX = 1440;
    localparam int LTF_NS_W = 14;
    localparam int BLOCK_W  = 15;
    localparam int TRAIN_W  = 16;

    // ceil numerator: service + 8*bytes + tail + dbps - 1
    localparam int NUM_MAX    = SERVICE_BITS + 8 * BYTES_CAP + TAIL_BITS + DBPS_MAX - 1;
    localparam int NUM_W      = $clog2(NUM_MAX + 1);
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int QW         = DIV_STAGES * DIV_BITS;
    localparam int PW         = QW + 16;

    localparam logic [1:0] LTF_1X     = 2'd0;
    localparam logic [1:0] LTF_2X     = 2'd1;
    localparam logic [1:0] LTF_2X_REP = 2'd2;

    localparam logic [7:0] PERIOD_4  = 8'd4;
    localparam logic [7:0] PERIOD_8  = 8'd8;
    localparam logic [7:0] PERIOD_16 = 8'd16;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_MCS = 2'd1,
        ST_BAD_NSS = 2'd2,
        ST_BAD_LTF = 2'd3
    } status_t;

    // per-transaction values that ride alongside the divider
    typedef struct packed {
        status_t              status;
        logic [DBPS_W-1:0]    dbps;
        logic [BLOCK_W-1:0]   block;
        logic [TRAIN_W-1:0]   training;
        logic [7:0]           period;
    } side_t;

    // data bits per symbol, zero for a combination not in the rate set
    function automatic logic [DBPS_W-1:0] dbps_lookup(
        input logic [3:0] mcs,
        input logic [7:0] mhz,
        input logic [2:0] nss
    );
        logic [DBPS_W-1:0] d;
        d = '0;
        if (mhz == 8'd10 && nss == 3'd1) begin
            case (mcs)
                4'd0:    d = 11'd26;
                4'd1:    d = 11'd52;
                4'd2:    d = 11'd78;
                4'd3:    d = 11'd104;
                4'd4:    d = 11'd156;
                4'd5:    d = 11'd208;
                4'd6:    d = 11'd234;
                4'd7:    d = 11'd260;
                4'd8:    d = 11'd312;
                4'd15:   d = 11'd13;
                default: d = '0;
            endcase
        end else if (mhz == 8'd10 && nss == 3'd2) begin
            case (mcs)
                4'd0:    d = 11'd52;
                4'd1:    d = 11'd104;
                4'd2:    d = 11'd156;
                4'd3:    d = 11'd208;
                4'd4:    d = 11'd312;
                4'd5:    d = 11'd416;
                4'd6:    d = 11'd468;
                4'd7:    d = 11'd520;
                4'd8:    d = 11'd624;
                default: d = '0;
            endcase
        end else if (mhz == 8'd20 && nss == 3'd1) begin
            case (mcs)
                4'd0:    d = 11'd54;
                4'd1:    d = 11'd108;
                4'd2:    d = 11'd162;
                4'd3:    d = 11'd216;
                4'd4:    d = 11'd324;
                4'd5:    d = 11'd432;
                4'd6:    d = 11'd486;
                4'd7:    d = 11'd540;
                4'd8:    d = 11'd648;
                4'd9:    d = 11'd720;
                4'd15:   d = 11'd27;
                default: d = '0;
            endcase
        end else if (mhz == 8'd20 && nss == 3'd2) begin
            case (mcs)
                4'd0:    d = 11'd108;
                4'd1:    d = 11'd216;
                4'd2:    d = 11'd324;
                4'd3:    d = 11'd432;
                4'd4:    d = 11'd648;
                4'd5:    d = 11'd864;
                4'd6:    d = 11'd972;
                4'd7:    d = 11'd1080;
                4'd8:    d = 11'd1296;
                4'd9:    d = 11'd1440;
                default: d = '0;
            endcase
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/ngvpa_div.sv =====
module ngvpa_div
    import ngvpa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [QW-1:0]     in_num,
    input  logic [DBPS_W-1:0] in_den,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [QW-1:0]     out_quo,
    output side_t             out_side
);

    // DIV_BITS restoring steps per stage, quotient bits shift in where numerator bits leave
    function automatic logic [QW+DBPS_W-1:0] div_chunk(
        input logic [QW-1:0]     nq,
        input logic [DBPS_W-1:0] rem,
        input logic [DBPS_W-1:0] den
    );
        logic [QW-1:0]     q;
        logic [DBPS_W-1:0] r;
        logic [DBPS_W:0]   t;
        q = nq;
        r = rem;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {r, q[QW-1]};
            q = {q[QW-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                t    = t - {1'b0, den};
                q[0] = 1'b1;
            end
            r = t[DBPS_W-1:0];
        end
        return {q, r};
    endfunction

    logic              valid_reg [DIV_STAGES];
    logic [QW-1:0]     nq_reg    [DIV_STAGES];
    logic [DBPS_W-1:0] rem_reg   [DIV_STAGES];
    logic [DBPS_W-1:0] den_reg   [DIV_STAGES];
    side_t             side_reg  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic              valid_in;
        logic [QW-1:0]     nq_in;
        logic [DBPS_W-1:0] rem_in;
        logic [DBPS_W-1:0] den_in;
        side_t             side_in;
        logic [QW-1:0]     nq_next;
        logic [DBPS_W-1:0] rem_next;

        if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign nq_in    = in_num;
            assign rem_in   = '0;
            assign den_in   = in_den;
            assign side_in  = in_side;
        end else begin : g_rest
            assign valid_in = valid_reg[k-1];
            assign nq_in    = nq_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        assign {nq_next, rem_next} = div_chunk(nq_in, rem_in, den_in);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[k]   <= nq_next;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quo   = nq_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

// ===== rtl/core/ngv_ppdu_airtime_calculator.sv =====
// NGV PPDU airtime calculator: each input transaction is one frame request and yields exactly
// one result transaction. Requests stream at one per clock while the result side accepts; the
// path runs through the input register, the pipelined restoring divider that forms
// ceil(bits / dbps) four quotient bits per stage, the midamble shift, the duration
// multipliers and the final add/saturate. A nonzero status in m_tuser marks a request with a
// bad stream count, an MCS/width/stream combination outside the rate set, or a bad LTF kind;
// all result fields are then zero. Backpressure on the result side stalls the whole pipeline.
module ngv_ppdu_airtime_calculator
    import ngvpa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // psdu_bytes[15:0], mcs_index[19:16], channel_mhz[27:20], stream_count[30:28],
    // ltf_kind[32:31], midamble_period[40:33], zero pad above
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bits_per_symbol[10:0], data_symbols[26:11], midamble_count[40:27],
    // payload_ns[70:41], training_ns[86:71], zero pad above
    output logic [87:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser
);

    logic en;

    logic [15:0] in_bytes;
    logic [3:0]  in_mcs;
    logic [7:0]  in_mhz;
    logic [2:0]  in_nss;
    logic [1:0]  in_ltf;
    logic [7:0]  in_period;

    assign in_bytes  = s_tdata[15:0];
    assign in_mcs    = s_tdata[19:16];
    assign in_mhz    = s_tdata[27:20];
    assign in_nss    = s_tdata[30:28];
    assign in_ltf    = s_tdata[32:31];
    assign in_period = s_tdata[40:33];

    // whole pipeline advances together whenever the output register can move
    assign en       = !m_tvalid || m_tready;
    // no transaction is taken while reset is held
    assign s_tready = en && aresetn;

    // ---------------- stage 1: table lookup, checks, numerator
    logic [DBPS_W-1:0]   dbps_c;
    logic [LTF_NS_W-1:0] ltf_ns_c;
    logic [BLOCK_W-1:0]  block_c;
    logic [15:0]         bytes_sat_c;
    side_t               side_next;
    logic [QW-1:0]       num_next;
    logic [DBPS_W-1:0]   den_next;

    always_comb begin
        dbps_c   = dbps_lookup(in_mcs, in_mhz, in_nss);
        ltf_ns_c = '0;
        case (in_ltf)
            LTF_1X:     ltf_ns_c = LTF_NS_W'(LTF_1X_NS);
            LTF_2X:     ltf_ns_c = LTF_NS_W'(LTF_2X_NS);
            LTF_2X_REP: ltf_ns_c = LTF_NS_W'(LTF_2X_REP_NS);
            default:    ltf_ns_c = '0;
        endcase

        side_next.status = ST_OK;
        if (in_nss < 3'd1 || in_nss > 3'd2) begin
            side_next.status = ST_BAD_NSS;
        end else if (dbps_c == '0) begin
            side_next.status = ST_BAD_MCS;
        end else if (ltf_ns_c == '0) begin
            side_next.status = ST_BAD_LTF;
        end

        block_c = (in_nss == 3'd2) ? {ltf_ns_c, 1'b0} : {1'b0, ltf_ns_c};

        side_next.dbps     = dbps_c;
        side_next.block    = block_c;
        side_next.training = TRAIN_W'(SYMBOL_NS) + TRAIN_W'(block_c);
        side_next.period   = in_period;

        bytes_sat_c = (32'(in_bytes) > MAX_PSDU_BYTES) ? 16'(MAX_PSDU_BYTES) : in_bytes;

        // error requests divide zero by one, their fields are cleared at the end
        if (side_next.status == ST_OK) begin
            num_next = (QW'(bytes_sat_c) << 3) + QW'(dbps_c)
                     + QW'(SERVICE_BITS + TAIL_BITS - 1);
            den_next = dbps_c;
        end else begin
            num_next = '0;
            den_next = DBPS_W'(1);
        end
    end

    logic              s1_valid_reg;
    logic [QW-1:0]     s1_num_reg;
    logic [DBPS_W-1:0] s1_den_reg;
    side_t             s1_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_num_reg  <= num_next;
            s1_den_reg  <= den_next;
            s1_side_reg <= side_next;
        end
    end

    // ---------------- divider stages
    logic          dv_valid;
    logic [QW-1:0] dv_quo;
    side_t         dv_side;

    ngvpa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .in_num    (s1_num_reg),
        .in_den    (s1_den_reg),
        .in_side   (s1_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // ---------------- midamble count
    logic [QW-1:0] syms_m1_c;
    logic [QW-1:0] mids_next;

    always_comb begin
        syms_m1_c = dv_quo - QW'(1);
        mids_next = '0;
        if (dv_quo != '0) begin
            case (dv_side.period)
                PERIOD_4:  mids_next = syms_m1_c >> 2;
                PERIOD_8:  mids_next = syms_m1_c >> 3;
                PERIOD_16: mids_next = syms_m1_c >> 4;
                default:   mids_next = '0;
            endcase
        end
    end

    logic          p1_valid_reg;
    logic [QW-1:0] p1_syms_reg;
    logic [QW-1:0] p1_mids_reg;
    side_t         p1_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_syms_reg <= dv_quo;
            p1_mids_reg <= mids_next;
            p1_side_reg <= dv_side;
        end
    end

    // ---------------- duration products
    logic [PW-1:0] sym_ns_next;
    logic [PW-1:0] mid_ns_next;

    assign sym_ns_next = PW'(p1_syms_reg) * PW'(SYMBOL_NS);
    assign mid_ns_next = PW'(p1_mids_reg) * PW'(p1_side_reg.block);

    logic          p2_valid_reg;
    logic [QW-1:0] p2_syms_reg;
    logic [QW-1:0] p2_mids_reg;
    logic [PW-1:0] p2_sym_ns_reg;
    logic [PW-1:0] p2_mid_ns_reg;
    side_t         p2_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_syms_reg   <= p1_syms_reg;
            p2_mids_reg   <= p1_mids_reg;
            p2_sym_ns_reg <= sym_ns_next;
            p2_mid_ns_reg <= mid_ns_next;
            p2_side_reg   <= p1_side_reg;
        end
    end

    // ---------------- sum, saturate, output register
    logic [PW-1:0] pay_c;
    logic [15:0]   syms_sat_c;
    logic [13:0]   mids_sat_c;
    logic [29:0]   pay_sat_c;
    logic [87:0]   tdata_next;
    logic [1:0]    tuser_next;

    always_comb begin
        pay_c      = p2_sym_ns_reg + p2_mid_ns_reg;
        syms_sat_c = (64'(p2_syms_reg) > 64'(SYM_MAX)) ? 16'(SYM_MAX) : 16'(p2_syms_reg);
        mids_sat_c = (64'(p2_mids_reg) > 64'(MID_MAX)) ? 14'(MID_MAX) : 14'(p2_mids_reg);
        pay_sat_c  = (64'(pay_c) > 64'(PAY_MAX)) ? 30'(PAY_MAX) : 30'(pay_c);
        tuser_next = p2_side_reg.status;
        if (p2_side_reg.status == ST_OK) begin
            tdata_next = {1'b0, p2_side_reg.training, pay_sat_c, mids_sat_c, syms_sat_c,
                          p2_side_reg.dbps};
        end else begin
            tdata_next = '0;
        end
    end

    logic        m_valid_reg;
    logic [87:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= tuser_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
